// ===== hdl/w2s_pkg.sv =====
// w2s_pkg: constants, widths and helpers for the world-to-screen projection core
// no dependencies
`timescale 1ns / 1ps

package w2s_pkg;

  // fraction bits of every fixed-point value
  localparam int FRAC_BITS = 16;

  // payload widths
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 14;
  localparam int HALF_W  = DIM_W - 1;
  localparam int CIDX_W  = 4;
  localparam int NCOEF   = 16;

  // product of a coordinate and a coefficient, then after the floor shift by the fraction bits
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SHP_W   = PROD_W - FRAC_BITS;
  // clip sum of three shifted products and a constant term
  localparam int CLIP_W  = SHP_W + 2;

  // ndc magnitude clamp at 2^48
  localparam int NDC_BITS = 48;
  localparam int DQ       = NDC_BITS - FRAC_BITS;
  localparam int NDC_W    = NDC_BITS + 2;
  localparam int DIV_N    = NDC_BITS;

  // half size times ndc, and the sum before saturation
  localparam int PX_W  = DIM_W + NDC_W;
  localparam int SUM_W = PX_W + 2;

  // visibility threshold, 0.1 in fixed point
  localparam int W_MIN_I = ((1 << FRAC_BITS) + 5) / 10;
  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(W_MIN_I);

  // configuration register indexes
  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  // input item codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);

  // sideband that travels with a point through the divider
  typedef struct packed {
    logic vld;
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ov_x;
    logic ov_y;
  } w2s_side_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7fff_ffff);
    lo = -SUM_W'(32'sh7fff_ffff) - SUM_W'(1);
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/world_to_screen_projection_core.sv =====
// world_to_screen_projection_core: pipelined matrix projection with a one-bit-per-stage divider
// depends on w2s_pkg
// throughput one point per cycle while the result channel is not stalled
// the 48-stage restoring divider (one quotient bit per stage, x and y side by side) sets the depth
// coefficient loads take effect at once and give no result beat
// reset (rst_ni low, asynchronous) clears the matrix, all valid bits, and sets the viewport
// to 1920 x 1080
`timescale 1ns / 1ps

module world_to_screen_projection_core import w2s_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [CIDX_W-1:0]        coef_index_i,
  input  logic signed [DATA_W-1:0] coef_value_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     visible_o,
  output logic signed [DATA_W-1:0] screen_x_o,
  output logic signed [DATA_W-1:0] screen_y_o,
  output logic signed [DATA_W-1:0] screen_z_o,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_wdata_i
);

  // whole pipeline moves when the output register is free or being emptied
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // viewport registers
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_WIDTH:  width_q  <= cfg_wdata_i;
        REG_WINDOW_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [HALF_W-1:0] hw;
  logic [HALF_W-1:0] hh;
  assign hw = width_q[DIM_W-1:1];
  assign hh = height_q[DIM_W-1:1];

  // matrix store, written on a load beat
  logic signed [DATA_W-1:0] coef_q [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (acc && func_i == FUNC_LOAD) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // stage a: capture point and rows 0, 1 and 3 of the matrix
  logic                     a_vld_q;
  logic signed [DATA_W-1:0] a_pos_q [3];
  logic signed [DATA_W-1:0] a_m_q   [12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= acc && func_i == FUNC_PROJECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pos_q[0] <= pos_x_i;
      a_pos_q[1] <= pos_y_i;
      a_pos_q[2] <= pos_z_i;
      for (int c = 0; c < 4; c++) begin
        a_m_q[c]     <= coef_q[c];
        a_m_q[4 + c] <= coef_q[4 + c];
        a_m_q[8 + c] <= coef_q[12 + c];
      end
    end
  end

  // stage b: nine products, floor shifted by the fraction bits
  logic                     b_vld_q;
  logic signed [SHP_W-1:0]  b_p_q [9];
  logic signed [DATA_W-1:0] b_k_q [3];
  logic signed [SHP_W-1:0]  b_p_d [9];

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod = PROD_W'(a_pos_q[c]) * PROD_W'(a_m_q[r*4 + c]);
        b_p_d[r*3 + c] = prod[PROD_W-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        b_p_q[i] <= b_p_d[i];
      end
      for (int r = 0; r < 3; r++) begin
        b_k_q[r] <= a_m_q[r*4 + 3];
      end
    end
  end

  // stage c: clip x, y and w
  logic                     c_vld_q;
  logic signed [CLIP_W-1:0] c_s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        c_s_q[r] <= CLIP_W'(b_k_q[r]) + CLIP_W'(b_p_q[r*3]) + CLIP_W'(b_p_q[r*3 + 1])
                    + CLIP_W'(b_p_q[r*3 + 2]);
      end
    end
  end

  // stage d: magnitudes, visibility, clamp test and divider start values
  logic [CLIP_W-1:0]   mag_x;
  logic [CLIP_W-1:0]   mag_y;
  logic [CLIP_W-1:0]   divisor;
  w2s_side_t           side_d;

  assign mag_x   = c_s_q[0][CLIP_W-1] ? CLIP_W'(-c_s_q[0]) : CLIP_W'(c_s_q[0]);
  assign mag_y   = c_s_q[1][CLIP_W-1] ? CLIP_W'(-c_s_q[1]) : CLIP_W'(c_s_q[1]);
  assign divisor = c_s_q[2];

  always_comb begin
    side_d.vld   = c_vld_q;
    side_d.vis   = c_s_q[2] >= W_MIN;
    side_d.neg_x = c_s_q[0][CLIP_W-1];
    side_d.neg_y = c_s_q[1][CLIP_W-1];
    // quotient reaches 2^48 exactly when the magnitude over 2^32 reaches the divisor
    side_d.ov_x  = (mag_x >> DQ) >= divisor;
    side_d.ov_y  = (mag_y >> DQ) >= divisor;
  end

  // divider pipeline, one quotient bit per stage for x and y
  w2s_side_t         dv_side_q [DIV_N+1];
  logic [CLIP_W-1:0] dv_d_q    [DIV_N+1];
  logic [CLIP_W-1:0] dv_rx_q   [DIV_N+1];
  logic [CLIP_W-1:0] dv_ry_q   [DIV_N+1];
  logic [NDC_BITS-1:0] dv_wx_q [DIV_N+1];
  logic [NDC_BITS-1:0] dv_wy_q [DIV_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_side_q[0] <= '0;
    end else if (en) begin
      dv_side_q[0] <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_d_q[0]  <= divisor;
      dv_rx_q[0] <= mag_x >> DQ;
      dv_ry_q[0] <= mag_y >> DQ;
      dv_wx_q[0] <= {mag_x[DQ-1:0], {FRAC_BITS{1'b0}}};
      dv_wy_q[0] <= {mag_y[DQ-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 1; k <= DIV_N; k++) begin : g_div
    logic [CLIP_W-1:0] tx;
    logic [CLIP_W-1:0] ty;
    logic              gx;
    logic              gy;

    assign tx = {dv_rx_q[k-1][CLIP_W-2:0], dv_wx_q[k-1][NDC_BITS-1]};
    assign ty = {dv_ry_q[k-1][CLIP_W-2:0], dv_wy_q[k-1][NDC_BITS-1]};
    assign gx = tx >= dv_d_q[k-1];
    assign gy = ty >= dv_d_q[k-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_side_q[k] <= '0;
      end else if (en) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_d_q[k]  <= dv_d_q[k-1];
        dv_rx_q[k] <= gx ? tx - dv_d_q[k-1] : tx;
        dv_ry_q[k] <= gy ? ty - dv_d_q[k-1] : ty;
        dv_wx_q[k] <= {dv_wx_q[k-1][NDC_BITS-2:0], gx};
        dv_wy_q[k] <= {dv_wy_q[k-1][NDC_BITS-2:0], gy};
      end
    end
  end

  // stage n: clamp and sign the quotients
  logic                    n_vld_q;
  logic                    n_vis_q;
  logic signed [NDC_W-1:0] n_x_q;
  logic signed [NDC_W-1:0] n_y_q;
  logic [NDC_W-1:0]        qx;
  logic [NDC_W-1:0]        qy;
  w2s_side_t               dv_last;

  assign dv_last = dv_side_q[DIV_N];
  assign qx = dv_last.ov_x ? NDC_W'(1) << NDC_BITS : NDC_W'(dv_wx_q[DIV_N]);
  assign qy = dv_last.ov_y ? NDC_W'(1) << NDC_BITS : NDC_W'(dv_wy_q[DIV_N]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (en) begin
      n_vld_q <= dv_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_vis_q <= dv_last.vis;
      n_x_q   <= dv_last.neg_x ? -$signed(qx) : $signed(qx);
      n_y_q   <= dv_last.neg_y ? -$signed(qy) : $signed(qy);
    end
  end

  // stage m: scale by the half sizes
  logic                   m_vld_q;
  logic                   m_vis_q;
  logic signed [PX_W-1:0] m_x_q;
  logic signed [PX_W-1:0] m_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_vis_q <= n_vis_q;
      m_x_q   <= PX_W'($signed({1'b0, hw})) * PX_W'(n_x_q);
      m_y_q   <= PX_W'($signed({1'b0, hh})) * PX_W'(n_y_q);
    end
  end

  // stage s: viewport offsets and saturation of x and y
  logic                     s_vld_q;
  logic                     s_vis_q;
  logic signed [DATA_W-1:0] s_x_q;
  logic signed [DATA_W-1:0] s_y_q;
  logic signed [SUM_W-1:0]  hw_q16;
  logic signed [SUM_W-1:0]  hh_q16;

  assign hw_q16 = $signed(SUM_W'(hw) << FRAC_BITS);
  assign hh_q16 = $signed(SUM_W'(hh) << FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_vis_q <= m_vis_q;
      s_x_q   <= sat32(SUM_W'(m_x_q) + hw_q16);
      s_y_q   <= sat32(hh_q16 - SUM_W'(m_y_q));
    end
  end

  // output register: screen z, invisible points forced to zero
  logic                     out_vld_q;
  logic                     out_vis_q;
  logic signed [DATA_W-1:0] out_x_q;
  logic signed [DATA_W-1:0] out_y_q;
  logic signed [DATA_W-1:0] out_z_q;
  logic signed [DATA_W-1:0] z_d;

  assign z_d = sat32(hh_q16 - (SUM_W'(s_y_q) <<< 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_vis_q <= s_vis_q;
      out_x_q   <= s_vis_q ? s_x_q : '0;
      out_y_q   <= s_vis_q ? s_y_q : '0;
      out_z_q   <= s_vis_q ? z_d   : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign visible_o   = out_vis_q;
  assign screen_x_o  = out_x_q;
  assign screen_y_o  = out_y_q;
  assign screen_z_o  = out_z_q;

  // hidden points leave with all coordinates zero
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0 && screen_z_o == '0)
    else $error("hidden point with nonzero coordinates");

  // a load beat lands in the matrix store
  a_coef_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_LOAD
    |=> coef_q[$past(coef_index_i)] == $past(coef_value_i))
    else $error("coefficient load lost");

  // a stall freezes the divider entry and its last stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> dv_side_q[0] == $past(dv_side_q[0]) && dv_side_q[DIV_N] == $past(dv_side_q[DIV_N]))
    else $error("divider moved during stall");

  // a load beat never starts a point
  a_load_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && func_i == FUNC_LOAD |=> !a_vld_q)
    else $error("load beat entered the pipeline");

endmodule
